/* rtl/register_write_sequence_checker_macros.svh */
// ----------------------------------------------------------------------------
// Register write sequence checker assertion macros
// Shorthand for the clocked assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef REGISTER_WRITE_SEQUENCE_CHECKER_MACROS_SVH
`define REGISTER_WRITE_SEQUENCE_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RWSC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RWSC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that is also checked through reset.
`define RWSC_ASSERT_ALWAYS_NEXT(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* rtl/rwsc_pkg.sv */
// ----------------------------------------------------------------------------
// Register write sequence checker package
// Field widths, action and entry kind codes, and the table entry type.
// ----------------------------------------------------------------------------
package rwsc_pkg;

  localparam int ACT_W  = 2;
  localparam int ADDR_W = 20;
  localparam int DATA_W = 16;
  localparam int SLOT_W = 4;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 5;
  localparam int CNT_W  = 16;

  localparam logic [ACT_W-1:0] ACT_OBSERVE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  localparam logic [KIND_W-1:0] KIND_EXACT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ANY      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONWRITE = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] mask;
    logic [KIND_W-1:0] kind;
  } entry_t;

endpackage

/* rtl/rwsc_in_if.sv */
// ----------------------------------------------------------------------------
// Register write sequence checker request channel
// Valid/ready channel carrying one observe, load or restart request.
// ----------------------------------------------------------------------------
interface rwsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [rwsc_pkg::ACT_W-1:0]  action;
  logic [rwsc_pkg::ADDR_W-1:0] address;
  logic [rwsc_pkg::DATA_W-1:0] value;
  logic [rwsc_pkg::DATA_W-1:0] mask;
  logic [rwsc_pkg::SLOT_W-1:0] entry_index;
  logic [rwsc_pkg::KIND_W-1:0] entry_kind;

  modport source (
    output valid, action, address, value, mask, entry_index, entry_kind,
    input  ready
  );
  modport sink (
    input  valid, action, address, value, mask, entry_index, entry_kind,
    output ready
  );
endinterface

/* rtl/rwsc_out_if.sv */
// ----------------------------------------------------------------------------
// Register write sequence checker result channel
// Valid/ready channel carrying the checker status after each request.
// ----------------------------------------------------------------------------
interface rwsc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       done_res;
  logic [rwsc_pkg::LEN_W-1:0] position;
  logic [rwsc_pkg::CNT_W-1:0] mismatch_count;
  logic                       mismatch_now;

  modport source (
    output valid, done_res, position, mismatch_count, mismatch_now,
    input  ready
  );
  modport sink (
    input  valid, done_res, position, mismatch_count, mismatch_now,
    output ready
  );
endinterface

/* rtl/register_write_sequence_checker.sv */
// ----------------------------------------------------------------------------
// Register write sequence checker
// Checks observed register writes in order against a table of expected writes.
// ----------------------------------------------------------------------------
// The block takes one request per clock while results are taken and returns
// exactly one result per request. The request is first held in an input
// register, then checked and the status written to the result register, from
// which it is offered. The expected entry at the current position is read
// from the table through a registered port addressed by the next position, so
// each check is a single compare and pointer update; a table load to the slot
// being read is bypassed into the read data. Throughput is one request per
// clock as long as results are taken. The table holds TABLE_DEPTH entries, of
// which the sixteen that a load can address are usable; the sequence length is
// written on the configuration port, and the user must write it only while the
// block is idle; the block itself does not enforce this.
module register_write_sequence_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [rwsc_pkg::LEN_W-1:0] cfg_wr_data,
  rwsc_in_if.sink                    in_req,
  rwsc_out_if.source                 out_res
);

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_CAP = (TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH;
  localparam logic [rwsc_pkg::LEN_W-1:0] LEN_CAP_V = rwsc_pkg::LEN_W'(LEN_CAP);

  logic [rwsc_pkg::LEN_W-1:0]  cfg_len_r;
  logic [rwsc_pkg::LEN_W-1:0]  len_act;

  logic                        s1_valid_r;
  logic [rwsc_pkg::ACT_W-1:0]  s1_action_r;
  logic [rwsc_pkg::ADDR_W-1:0] s1_addr_r;
  logic [rwsc_pkg::DATA_W-1:0] s1_value_r;
  logic [rwsc_pkg::DATA_W-1:0] s1_mask_r;
  logic [rwsc_pkg::SLOT_W-1:0] s1_slot_r;
  logic [rwsc_pkg::KIND_W-1:0] s1_kind_r;

  logic [rwsc_pkg::LEN_W-1:0]  pos_r, pos_nxt;
  logic                        done_r, done_nxt;
  logic [rwsc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        miss_r, miss_nxt;
  logic                        out_valid_r;

  logic                        advance;
  logic                        hit;
  logic                        slot_ok;
  logic                        wr_en;
  rwsc_pkg::entry_t            wr_data;
  rwsc_pkg::entry_t            ent;

  assign advance      = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_req.ready = !s1_valid_r || advance;

  assign len_act = (cfg_len_r > LEN_CAP_V) ? LEN_CAP_V : cfg_len_r;
  assign hit     = ((s1_value_r & s1_mask_r & ent.mask) == (ent.value & ent.mask));
  assign slot_ok = (int'(s1_slot_r) < TABLE_DEPTH);

  assign wr_data.address = s1_addr_r;
  assign wr_data.value   = s1_value_r;
  assign wr_data.mask    = s1_mask_r;
  assign wr_data.kind    = s1_kind_r;

  rwsc_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (IDX_W'(s1_slot_r)),
    .wr_data (wr_data),
    .rd_idx  (IDX_W'(pos_nxt)),
    .rd_data (ent)
  );

  always_comb begin
    pos_nxt  = pos_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    miss_nxt = 1'b0;
    wr_en    = 1'b0;
    if (advance) begin
      case (s1_action_r)
        rwsc_pkg::ACT_OBSERVE: begin
          if ((len_act != '0) && !done_r) begin
            if (pos_r >= len_act) begin
              done_nxt = 1'b1;
            end else if (s1_addr_r == ent.address) begin
              if (ent.kind inside {rwsc_pkg::KIND_EXACT, rwsc_pkg::KIND_ANY}) begin
                if (hit || (ent.kind == rwsc_pkg::KIND_ANY)) begin
                  pos_nxt = pos_r + rwsc_pkg::LEN_W'(1);
                  if (pos_nxt >= len_act) begin
                    done_nxt = 1'b1;
                  end
                end else begin
                  pos_nxt  = '0;
                  miss_nxt = 1'b1;
                  if (cnt_r != rwsc_pkg::COUNT_MAX) begin
                    cnt_nxt = cnt_r + rwsc_pkg::CNT_W'(1);
                  end
                end
              end
            end
          end
        end
        rwsc_pkg::ACT_LOAD: begin
          wr_en = slot_ok;
        end
        rwsc_pkg::ACT_RESTART: begin
          if (cfg_len_r != '0) begin
            pos_nxt  = '0;
            done_nxt = 1'b0;
            cnt_nxt  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= '0;
      s1_valid_r  <= 1'b0;
      pos_r       <= '0;
      done_r      <= 1'b0;
      cnt_r       <= '0;
      miss_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      if (in_req.ready) begin
        s1_valid_r <= in_req.valid;
      end
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      if (advance) begin
        miss_r      <= miss_nxt;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_action_r <= in_req.action;
      s1_addr_r   <= in_req.address;
      s1_value_r  <= in_req.value;
      s1_mask_r   <= in_req.mask;
      s1_slot_r   <= in_req.entry_index;
      s1_kind_r   <= in_req.entry_kind;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.done_res       = done_r;
  assign out_res.position       = pos_r;
  assign out_res.mismatch_count = cnt_r;
  assign out_res.mismatch_now   = miss_r;

endmodule

/* rtl/rwsc_table.sv */
// ----------------------------------------------------------------------------
// Register write sequence checker expected write table
// One write port and one registered read port, with write-to-read bypass.
// ----------------------------------------------------------------------------
module rwsc_table #(
  parameter  int DEPTH = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  rwsc_pkg::entry_t wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output rwsc_pkg::entry_t rd_data
);

  rwsc_pkg::entry_t mem [DEPTH];
  rwsc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (wr_en && (wr_idx == rd_idx)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/rwsc_checker.sv */
// ----------------------------------------------------------------------------
// Register write sequence checker port checker
// Assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "register_write_sequence_checker_macros.svh"

module rwsc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       done_res,
  input logic [rwsc_pkg::LEN_W-1:0] position,
  input logic [rwsc_pkg::CNT_W-1:0] mismatch_count,
  input logic                       mismatch_now
);

  logic [rwsc_pkg::LEN_W+rwsc_pkg::CNT_W+1:0] res_bits;

  assign res_bits = {done_res, position, mismatch_count, mismatch_now};

  // No result is offered in the cycle after reset.
  `RWSC_ASSERT_ALWAYS_NEXT(a_reset_idle, clk, !rst_n, !out_valid)

  // A stalled result keeps its contents.
  `RWSC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res_bits))

  // A mismatch restarts the sequence, which cannot be complete.
  `RWSC_ASSERT_NOW(a_miss_restart, clk, rst_n, out_valid && mismatch_now, (position == '0) && !done_res)

  // A mismatch leaves the count nonzero; the count saturates at its maximum.
  `RWSC_ASSERT_NOW(a_miss_counted, clk, rst_n, out_valid && mismatch_now, mismatch_count != '0)

endmodule

bind register_write_sequence_checker rwsc_checker u_rwsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .done_res       (out_res.done_res),
  .position       (out_res.position),
  .mismatch_count (out_res.mismatch_count),
  .mismatch_now   (out_res.mismatch_now)
);

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Register write sequence checker testbench
// Drives observe, load and restart requests with random gaps on both sides,
// tracks the expected checker status for every accepted request and compares
// it with each result. The run covers directed corner cases, random sequences
// over several sequence lengths and a long result stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1780;
  localparam int LONG_STALL = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [rwsc_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [rwsc_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [rwsc_pkg::ACT_W-1:0]  action;
    logic [rwsc_pkg::ADDR_W-1:0] address;
    logic [rwsc_pkg::DATA_W-1:0] value;
    logic [rwsc_pkg::DATA_W-1:0] mask;
    logic [rwsc_pkg::SLOT_W-1:0] entry_index;
    logic [rwsc_pkg::KIND_W-1:0] entry_kind;
  } request_t;

  typedef struct packed {
    logic                       done;
    logic [rwsc_pkg::LEN_W-1:0] position;
    logic [rwsc_pkg::CNT_W-1:0] count;
    logic                       now;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [rwsc_pkg::LEN_W-1:0] cfg_wr_data = '0;
  logic drv_valid = 1'b0;
  request_t drv_req = '0;
  logic rx_ready = 1'b0;
  logic in_fire_q = 1'b0;

  request_t request_q[$];
  status_t pending_status[$];
  int unsigned pushed = 0;
  int unsigned accepted = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_hold = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  bit idle_en = 1'b1;
  int unsigned cur_len = 0;

  rwsc_pkg::entry_t plan [TABLE_DEPTH];
  rwsc_pkg::entry_t model_table [TABLE_DEPTH];
  logic [rwsc_pkg::LEN_W-1:0] seq_len = '0;
  logic [rwsc_pkg::LEN_W-1:0] seq_pos = '0;
  logic seq_done = 1'b0;
  logic [rwsc_pkg::CNT_W-1:0] restart_cnt = '0;

  rwsc_in_if in_req();
  rwsc_out_if out_res();

  assign in_req.valid = drv_valid;
  assign in_req.action = drv_req.action;
  assign in_req.address = drv_req.address;
  assign in_req.value = drv_req.value;
  assign in_req.mask = drv_req.mask;
  assign in_req.entry_index = drv_req.entry_index;
  assign in_req.entry_kind = drv_req.entry_kind;
  assign out_res.ready = rx_ready;

  register_write_sequence_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_req(in_req),
    .out_res(out_res)
  );

  always #5 clk = ~clk;

  function automatic status_t status_after(request_t r);
    status_t s;
    logic [rwsc_pkg::LEN_W-1:0] len;
    rwsc_pkg::entry_t e;
    logic hit_now;
    hit_now = 1'b0;
    len = (seq_len > rwsc_pkg::LEN_W'(TABLE_DEPTH)) ? rwsc_pkg::LEN_W'(TABLE_DEPTH) : seq_len;
    case (r.action)
      rwsc_pkg::ACT_OBSERVE: begin
        if (len != '0 && !seq_done) begin
          if (seq_pos >= len) begin
            seq_done = 1'b1;
          end else begin
            e = model_table[seq_pos[rwsc_pkg::SLOT_W-1:0]];
            if (r.address == e.address &&
                (e.kind == rwsc_pkg::KIND_EXACT || e.kind == rwsc_pkg::KIND_ANY)) begin
              if (e.kind == rwsc_pkg::KIND_ANY ||
                  (r.value & r.mask & e.mask) == (e.value & e.mask)) begin
                seq_pos = seq_pos + rwsc_pkg::LEN_W'(1);
                if (seq_pos >= len) seq_done = 1'b1;
              end else begin
                seq_pos = '0;
                if (restart_cnt != rwsc_pkg::COUNT_MAX)
                  restart_cnt = restart_cnt + rwsc_pkg::CNT_W'(1);
                hit_now = 1'b1;
              end
            end
          end
        end
      end
      rwsc_pkg::ACT_LOAD: begin
        model_table[r.entry_index] = '{address: r.address, value: r.value,
                                       mask: r.mask, kind: r.entry_kind};
      end
      rwsc_pkg::ACT_RESTART: begin
        if (seq_len != '0) begin
          seq_pos = '0;
          seq_done = 1'b0;
          restart_cnt = '0;
        end
      end
      default: begin
      end
    endcase
    s.done = seq_done;
    s.position = seq_pos;
    s.count = restart_cnt;
    s.now = hit_now;
    return s;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic request_t rand_request();
    request_t r;
    r.action = rwsc_pkg::ACT_W'($urandom_range(0, 3));
    r.address = rwsc_pkg::ADDR_W'($urandom);
    r.value = rwsc_pkg::DATA_W'($urandom);
    r.mask = rwsc_pkg::DATA_W'($urandom);
    r.entry_index = rwsc_pkg::SLOT_W'($urandom);
    r.entry_kind = rwsc_pkg::KIND_W'($urandom);
    return r;
  endfunction

  function automatic logic [rwsc_pkg::DATA_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return rwsc_pkg::DATA_W'($urandom);
  endfunction

  function automatic logic [rwsc_pkg::ADDR_W-1:0] pick_address();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return rwsc_pkg::ADDR_W'($urandom_range(0, 7));
    if (r < 60) return '1;
    return rwsc_pkg::ADDR_W'($urandom);
  endfunction

  function automatic logic [rwsc_pkg::KIND_W-1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return rwsc_pkg::KIND_EXACT;
    if (r < 90) return rwsc_pkg::KIND_ANY;
    if (r < 96) return rwsc_pkg::KIND_NONWRITE;
    return KIND_SPARE;
  endfunction

  task automatic push(request_t r);
    request_q = {request_q, r};
    pushed++;
  endtask

  task automatic load_entry(int slot, logic [rwsc_pkg::ADDR_W-1:0] a,
                            logic [rwsc_pkg::DATA_W-1:0] v,
                            logic [rwsc_pkg::DATA_W-1:0] m,
                            logic [rwsc_pkg::KIND_W-1:0] k);
    request_t r;
    r = rand_request();
    r.action = rwsc_pkg::ACT_LOAD;
    r.address = a;
    r.value = v;
    r.mask = m;
    r.entry_index = slot[rwsc_pkg::SLOT_W-1:0];
    r.entry_kind = k;
    plan[slot] = '{address: a, value: v, mask: m, kind: k};
    push(r);
  endtask

  task automatic observe_write(logic [rwsc_pkg::ADDR_W-1:0] a,
                               logic [rwsc_pkg::DATA_W-1:0] v,
                               logic [rwsc_pkg::DATA_W-1:0] m);
    request_t r;
    r = rand_request();
    r.action = rwsc_pkg::ACT_OBSERVE;
    r.address = a;
    r.value = v;
    r.mask = m;
    push(r);
  endtask

  task automatic send_command(logic [rwsc_pkg::ACT_W-1:0] act);
    request_t r;
    r = rand_request();
    r.action = act;
    push(r);
  endtask

  task automatic hit(int p);
    rwsc_pkg::entry_t e;
    logic [rwsc_pkg::DATA_W-1:0] v, m;
    e = plan[p];
    m = e.mask | rwsc_pkg::DATA_W'($urandom);
    v = (e.value & e.mask) | (rwsc_pkg::DATA_W'($urandom) & ~e.mask);
    if (e.kind == rwsc_pkg::KIND_ANY) begin
      m = rwsc_pkg::DATA_W'($urandom);
      v = rwsc_pkg::DATA_W'($urandom);
    end
    observe_write(e.address, v, m);
  endtask

  task automatic miss_write(int p);
    rwsc_pkg::entry_t e;
    e = plan[p];
    observe_write(e.address, ~e.value ^ (rwsc_pkg::DATA_W'($urandom) & ~e.mask), '1);
  endtask

  task automatic play_sequence(int n);
    int retries;
    retries = 0;
    send_command(rwsc_pkg::ACT_RESTART);
    for (int p = 0; p < n; p++) begin
      if ($urandom_range(0, 99) < 8)
        observe_write(rwsc_pkg::ADDR_W'($urandom), rwsc_pkg::DATA_W'($urandom),
                      rwsc_pkg::DATA_W'($urandom));
      if ($urandom_range(0, 99) < 6 && retries < 3) begin
        miss_write(p);
        retries++;
        p = -1;
      end else begin
        hit(p);
      end
    end
    repeat ($urandom_range(0, 2)) hit($urandom_range(0, TABLE_DEPTH - 1));
  endtask

  task automatic load_random_table();
    for (int slot = 0; slot < TABLE_DEPTH; slot++)
      load_entry(slot, pick_address(), pick_word(), pick_word(), pick_kind());
  endtask

  task automatic random_step();
    int unsigned eff, r;
    request_t q;
    eff = (cur_len > TABLE_DEPTH) ? TABLE_DEPTH : cur_len;
    if (eff == 0) eff = $urandom_range(1, TABLE_DEPTH);
    r = $urandom_range(0, 99);
    if (r < 65) begin
      play_sequence($urandom_range(0, 3) == 0 ? $urandom_range(1, eff) : eff);
    end else if (r < 77) begin
      load_entry($urandom_range(0, TABLE_DEPTH - 1),
                 $urandom_range(0, 1) ? plan[$urandom_range(0, TABLE_DEPTH - 1)].address
                                      : pick_address(),
                 pick_word(), pick_word(), pick_kind());
    end else if (r < 89) begin
      repeat ($urandom_range(1, 4))
        observe_write(plan[$urandom_range(0, TABLE_DEPTH - 1)].address,
                      pick_word(), pick_word());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        q = rand_request();
        if (q.action == rwsc_pkg::ACT_LOAD)
          plan[q.entry_index] = '{address: q.address, value: q.value,
                                  mask: q.mask, kind: q.entry_kind};
        push(q);
      end
    end
  endtask

  task automatic drain();
    while (accepted != pushed || pending_status.size() != 0) @(negedge clk);
  endtask

  // The length may only change once every outstanding request has been answered.
  task automatic write_length(logic [rwsc_pkg::LEN_W-1:0] len);
    drain();
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    cur_len = 32'(len);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (drv_valid && !in_fire_q) begin
    end else if (tx_gap != 0) begin
      tx_gap--;
      drv_valid <= 1'b0;
    end else if (request_q.size() != 0) begin
      drv_req <= request_q.pop_front();
      drv_valid <= 1'b1;
      tx_gap = pick_gap();
    end else begin
      drv_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        rx_hold = LONG_STALL;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
        rx_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    status_t got, want, pred;
    if (!rst_n) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_req.valid && in_req.ready;
      if (cfg_wr_en) seq_len = cfg_wr_data;
      if (in_req.valid && in_req.ready) begin
        pred = status_after(drv_req);
        pending_status = {pending_status, pred};
        accepted++;
      end
      if (out_res.valid && out_res.ready) begin
        got.done = out_res.done_res;
        got.position = out_res.position;
        got.count = out_res.mismatch_count;
        got.now = out_res.mismatch_now;
        if (pending_status.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected result at %0t: done %0b pos %0d count %0d now %0b",
                     $time, got.done, got.position, got.count, got.now);
        end else begin
          want = pending_status.pop_front();
          if (got.done !== want.done || got.position !== want.position ||
              got.count !== want.count || got.now !== want.now) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch at %0t: expected done %0b pos %0d count %0d now %0b",
                       $time, want.done, want.position, want.count, want.now);
              $display("                 got      done %0b pos %0d count %0d now %0b",
                       got.done, got.position, got.count, got.now);
            end
          end
        end
      end
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len_now;
    int phase;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // With the length still zero, every request leaves the status alone.
    observe_write(20'h00000, 16'h0000, 16'h0000);
    send_command(rwsc_pkg::ACT_RESTART);
    send_command(ACT_UNUSED);
    load_entry(0, 20'hFFFFF, 16'hFFFF, 16'hFFFF, rwsc_pkg::KIND_EXACT);
    load_entry(1, 20'h00000, 16'h00A5, 16'h00FF, rwsc_pkg::KIND_ANY);
    load_entry(2, 20'h12345, 16'h0000, 16'h0000, rwsc_pkg::KIND_NONWRITE);
    load_entry(15, 20'h00000, 16'h0000, 16'h0000, KIND_SPARE);
    write_length(5'd3);
    observe_write(20'h54321, 16'hFFFF, 16'hFFFF);
    observe_write(20'hFFFFF, 16'hFFFF, 16'h7FFF);
    observe_write(20'hFFFFF, 16'hFFFF, 16'hFFFF);
    observe_write(20'h00000, 16'h1234, 16'h0000);
    observe_write(20'h12345, 16'h0000, 16'h0000);
    send_command(ACT_UNUSED);
    send_command(rwsc_pkg::ACT_RESTART);
    hit(0);
    hit(1);
    load_entry(2, 20'h12345, 16'h8001, 16'h8001, rwsc_pkg::KIND_EXACT);
    observe_write(20'h12345, 16'h8001, 16'hFFFF);
    observe_write(20'hFFFFF, 16'hFFFF, 16'hFFFF);
    send_command(rwsc_pkg::ACT_RESTART);
    hit(0);
    hit(1);
    // Shortening the length below the current position completes the sequence.
    write_length(5'd1);
    observe_write(20'h00000, 16'h0000, 16'h0000);

    load_random_table();
    phase = 0;
    while (pushed < RANDOM_ITEMS) begin
      case (phase % 6)
        0: len_now = TABLE_DEPTH;
        1: len_now = 31;
        2: len_now = 1;
        3: len_now = 0;
        default: len_now = $urandom_range(1, TABLE_DEPTH);
      endcase
      write_length(len_now[rwsc_pkg::LEN_W-1:0]);
      idle_en = ($urandom_range(0, 3) != 0);
      if (phase == 4) stall_requests++;
      repeat ((len_now == 0) ? 3 : $urandom_range(5, 12)) random_step();
      phase++;
    end

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending_status.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
